### rtl/topological_sort_engine_unit_macros.svh
// assertion macros for the topological sort engine
// used by the top level only, clocked on clock and quiet during reset
`ifndef TOPOLOGICAL_SORT_ENGINE_UNIT_MACROS_SVH
`define TOPOLOGICAL_SORT_ENGINE_UNIT_MACROS_SVH

// condition holds in the same cycle
`define TSE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tse_pkg.sv
// shared types and constants of the topological sort engine
// no dependencies
`timescale 1ns / 1ps

package tse_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;

   localparam int NODE_W   = 11;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int MARK_W   = 2;

   localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RUN  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CYCLE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_OPEN = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DONE = 2'd2;

endpackage

### rtl/tse_ram.sv
// generic single-port-write, single-port-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module tse_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/topological_sort_engine_unit.sv
// top level of the topological sort engine: request decode, walk sequencer, memories
// depends on tse_pkg, tse_ram and topological_sort_engine_unit_macros.svh
`timescale 1ns / 1ps
`include "topological_sort_engine_unit_macros.svh"

// Usage
//   req channel: req_type 0 adds an edge prerequisite -> dependent, 1 runs the
//   sort, 2 reads the next order word (top first). rsp channel returns status,
//   node, order_count and last_entry. csr channel writes node_count (roots 1..n).
//   An add gives no word unless the edge store is full. A run first sweeps
//   the visit marks, then tests each root, enters nodes, follows edges and
//   finishes nodes in turn; the mark memory's single read port sets the
//   pace of the walk.
//   One request is worked at a time. The next request is taken once the block
//   is idle and the response register is empty or being drained, so a stalled
//   receiver holds off new requests but never loses a word.
//   After reset the block clears the list heads before req_ready rises;
//   csr writes are accepted at any time.
module topological_sort_engine_unit
   import tse_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [NODE_W-1:0]   req_dependent_node,
   input  logic [NODE_W-1:0]   req_prerequisite_node,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [NODE_W-1:0]   rsp_node,
   output logic [NODE_W-1:0]   rsp_order_count,
   output logic                rsp_last_entry,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [NODE_W-1:0]   csr_node_count
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int RW  = $clog2(MAX_NODES + 2);
   localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

   typedef enum logic [11:0] {
      S_INIT    = 12'b000000000001,
      S_IDLE    = 12'b000000000010,
      S_ADD     = 12'b000000000100,
      S_READ    = 12'b000000001000,
      S_CLEAR   = 12'b000000010000,
      S_ROOT    = 12'b000000100000,
      S_ROOTCHK = 12'b000001000000,
      S_PUSH    = 12'b000010000000,
      S_STEP    = 12'b000100000000,
      S_POP     = 12'b001000000000,
      S_EDGE    = 12'b010000000000,
      S_MARK    = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [RW-1:0]      root_ff, root_in;
   logic [CW-1:0]      sp_ff, sp_in;
   logic [CW-1:0]      placed_ff, placed_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [CW-1:0]      rp_ff, rp_in;
   logic [EW-1:0]      edge_total_ff, edge_total_in;
   logic               ovf_ff, ovf_in;
   logic [NODE_W-1:0]  node_count_ff;
   logic [NW-1:0]      top_node_ff, top_node_in;
   logic [EW-1:0]      top_cur_ff, top_cur_in;
   logic [NW-1:0]      tgt_ff, tgt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [NODE_W-1:0]  rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory ports
   logic               nd_we, nd_re;
   logic [NW-1:0]      nd_waddr, nd_raddr;
   logic [2*EW-1:0]    nd_wdata, nd_rdata;
   logic               lk_we, tg_we, ed_re;
   logic [EAW-1:0]     lk_waddr, tg_waddr, ed_raddr;
   logic [EW-1:0]      lk_wdata, lk_rdata;
   logic [NW-1:0]      tg_wdata, tg_rdata;
   logic               mk_we, mk_re;
   logic [NW-1:0]      mk_waddr, mk_raddr;
   logic [MARK_W-1:0]  mk_wdata, mk_rdata;
   logic               st_we, st_re;
   logic [NW-1:0]      st_waddr, st_raddr;
   logic [NW+EW-1:0]   st_wdata, st_rdata;
   logic               od_we, od_re;
   logic [NW-1:0]      od_waddr, od_raddr;
   logic [NW-1:0]      od_wdata, od_rdata;

   logic               req_fire;
   logic               dep_ok, pre_ok;
   logic [CW-1:0]      roots;
   logic [EW-1:0]      nd_head, nd_tail;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign dep_ok = (req_dependent_node != '0) && (32'(req_dependent_node) <= MAX_NODES);
   assign pre_ok = (req_prerequisite_node != '0)
                   && (32'(req_prerequisite_node) <= MAX_NODES);
   assign roots  = (32'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
   assign nd_head = nd_rdata[2*EW-1:EW];
   assign nd_tail = nd_rdata[EW-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      root_in       = root_ff;
      sp_in         = sp_ff;
      placed_in     = placed_ff;
      len_in        = len_ff;
      rp_in         = rp_ff;
      edge_total_in = edge_total_ff;
      ovf_in        = ovf_ff;
      top_node_in   = top_node_ff;
      top_cur_in    = top_cur_ff;
      tgt_in        = tgt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_re = 1'b0; nd_raddr = '0;
      lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0;
      tg_we = 1'b0; tg_waddr = '0; tg_wdata = '0;
      ed_re = 1'b0; ed_raddr = '0;
      mk_we = 1'b0; mk_waddr = '0; mk_wdata = '0; mk_re = 1'b0; mk_raddr = '0;
      st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;
      od_we = 1'b0; od_waddr = '0; od_wdata = '0; od_re = 1'b0; od_raddr = '0;

      unique case (state_ff)
         S_INIT: begin
            nd_we    = 1'b1;
            nd_waddr = cnt_ff;
            nd_wdata = {NIL, EW'(0)};
            cnt_in   = cnt_ff + NW'(1);
            if (cnt_ff == NW'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_type)
                  REQ_ADD: begin
                     if (dep_ok && pre_ok) begin
                        if (edge_total_ff == NIL) begin
                           ovf_in        = 1'b1;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_OVERFLOW;
                           rsp_node_in   = '0;
                           rsp_count_in  = NODE_W'(len_ff);
                           rsp_last_in   = 1'b0;
                        end else begin
                           tg_we    = 1'b1;
                           tg_waddr = edge_total_ff[EAW-1:0];
                           tg_wdata = NW'(req_dependent_node - NODE_W'(1));
                           lk_we    = 1'b1;
                           lk_waddr = edge_total_ff[EAW-1:0];
                           lk_wdata = NIL;
                           nd_re    = 1'b1;
                           nd_raddr = NW'(req_prerequisite_node - NODE_W'(1));
                           tgt_in   = NW'(req_prerequisite_node - NODE_W'(1));
                           state_in = S_ADD;
                        end
                     end
                  end
                  REQ_RUN: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  REQ_READ: begin
                     if (rp_ff < len_ff) begin
                        od_re    = 1'b1;
                        od_raddr = NW'(len_ff - rp_ff - CW'(1));
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_node_in   = '0;
                        rsp_count_in  = NODE_W'(len_ff);
                        rsp_last_in   = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD: begin
            // append to the source list; link the old tail when the list is not empty
            nd_we    = 1'b1;
            nd_waddr = tgt_ff;
            if (nd_head == NIL) begin
               nd_wdata = {edge_total_ff, edge_total_ff};
            end else begin
               nd_wdata = {nd_head, edge_total_ff};
               lk_we    = 1'b1;
               lk_waddr = nd_tail[EAW-1:0];
               lk_wdata = edge_total_ff;
            end
            edge_total_in = edge_total_ff + EW'(1);
            state_in      = S_IDLE;
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_node_in   = NODE_W'({1'b0, od_rdata} + (NW + 1)'(1));
            rsp_count_in  = NODE_W'(len_ff);
            rsp_last_in   = ((rp_ff + CW'(1)) == len_ff);
            rp_in         = rp_ff + CW'(1);
            state_in      = S_IDLE;
         end
         S_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = cnt_ff;
            mk_wdata = MARK_NONE;
            cnt_in   = cnt_ff + NW'(1);
            if (cnt_ff == NW'(MAX_NODES - 1)) begin
               root_in   = RW'(1);
               sp_in     = '0;
               placed_in = '0;
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            if (32'(root_ff) > 32'(roots)) begin
               len_in        = placed_ff;
               rp_in         = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ovf_ff ? ST_OVERFLOW : ST_DONE;
               rsp_node_in   = '0;
               rsp_count_in  = NODE_W'(placed_ff);
               rsp_last_in   = 1'b0;
               state_in      = S_IDLE;
            end else begin
               mk_re    = 1'b1;
               mk_raddr = NW'(root_ff - RW'(1));
               state_in = S_ROOTCHK;
            end
         end
         S_ROOTCHK: begin
            if (mk_rdata != MARK_NONE) begin
               root_in  = root_ff + RW'(1);
               state_in = S_ROOT;
            end else begin
               mk_we    = 1'b1;
               mk_waddr = NW'(root_ff - RW'(1));
               mk_wdata = MARK_OPEN;
               nd_re    = 1'b1;
               nd_raddr = NW'(root_ff - RW'(1));
               tgt_in   = NW'(root_ff - RW'(1));
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            top_node_in = tgt_ff;
            top_cur_in  = nd_head;
            sp_in       = sp_ff + CW'(1);
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (top_cur_ff == NIL) begin
               // node finished: postorder append, then resume the entry below or, if none, the next root
               od_we     = 1'b1;
               od_waddr  = NW'(placed_ff);
               od_wdata  = top_node_ff;
               placed_in = placed_ff + CW'(1);
               mk_we     = 1'b1;
               mk_waddr  = top_node_ff;
               mk_wdata  = MARK_DONE;
               sp_in     = sp_ff - CW'(1);
               if (sp_ff == CW'(1)) begin
                  root_in  = root_ff + RW'(1);
                  state_in = S_ROOT;
               end else begin
                  st_re    = 1'b1;
                  st_raddr = NW'(sp_ff - CW'(2));
                  state_in = S_POP;
               end
            end else begin
               ed_re    = 1'b1;
               ed_raddr = top_cur_ff[EAW-1:0];
               state_in = S_EDGE;
            end
         end
         S_POP: begin
            top_node_in = st_rdata[NW+EW-1:EW];
            top_cur_in  = st_rdata[EW-1:0];
            state_in    = S_STEP;
         end
         S_EDGE: begin
            top_cur_in = lk_rdata;
            tgt_in     = tg_rdata;
            mk_re      = 1'b1;
            mk_raddr   = tg_rdata;
            state_in   = S_MARK;
         end
         S_MARK: begin
            priority if (mk_rdata == MARK_DONE) begin
               state_in = S_STEP;
            end else if (mk_rdata == MARK_OPEN) begin
               // target still on the path
               len_in        = '0;
               rp_in         = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_CYCLE;
               rsp_node_in   = '0;
               rsp_count_in  = NODE_W'(placed_ff);
               rsp_last_in   = 1'b0;
               state_in      = S_IDLE;
            end else begin
               st_we    = 1'b1;
               st_waddr = NW'(sp_ff - CW'(1));
               st_wdata = {top_node_ff, top_cur_ff};
               mk_we    = 1'b1;
               mk_waddr = tgt_ff;
               mk_wdata = MARK_OPEN;
               nd_re    = 1'b1;
               nd_raddr = tgt_ff;
               state_in = S_PUSH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         root_ff       <= '0;
         sp_ff         <= '0;
         placed_ff     <= '0;
         len_ff        <= '0;
         rp_ff         <= '0;
         edge_total_ff <= '0;
         ovf_ff        <= 1'b0;
         node_count_ff <= NODE_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         root_ff       <= root_in;
         sp_ff         <= sp_in;
         placed_ff     <= placed_in;
         len_ff        <= len_in;
         rp_ff         <= rp_in;
         edge_total_ff <= edge_total_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_node_ff   <= top_node_in;
      top_cur_ff    <= top_cur_in;
      tgt_ff        <= tgt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node        = rsp_node_ff;
   assign rsp_order_count = rsp_count_ff;
   assign rsp_last_entry  = rsp_last_ff;

   // per node list head and tail
   tse_ram #(.WIDTH(2 * EW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(nd_we), .wr_addr(nd_waddr), .wr_data(nd_wdata),
      .rd_en(nd_re), .rd_addr(nd_raddr), .rd_data(nd_rdata)
   );

   tse_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link_ram (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
      .rd_en(ed_re), .rd_addr(ed_raddr), .rd_data(lk_rdata)
   );

   tse_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_target_ram (
      .clock(clock), .wr_en(tg_we), .wr_addr(tg_waddr), .wr_data(tg_wdata),
      .rd_en(ed_re), .rd_addr(ed_raddr), .rd_data(tg_rdata)
   );

   tse_ram #(.WIDTH(MARK_W), .DEPTH(MAX_NODES)) u_mark_ram (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
      .rd_en(mk_re), .rd_addr(mk_raddr), .rd_data(mk_rdata)
   );

   // walk stack below the cached top entry
   tse_ram #(.WIDTH(NW + EW), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_en(st_re), .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   tse_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order_ram (
      .clock(clock), .wr_en(od_we), .wr_addr(od_waddr), .wr_data(od_wdata),
      .rd_en(od_re), .rd_addr(od_raddr), .rd_data(od_rdata)
   );

   `TSE_ASSERT_NOW(a_push_room, state_ff == S_PUSH, 32'(sp_ff) < MAX_NODES, "stack overflow on push")
   `TSE_ASSERT_NOW(a_len_bound, 1'b1, 32'(len_ff) <= MAX_NODES, "order length out of range")
   `TSE_ASSERT_NOW(a_rp_bound, 1'b1, rp_ff <= len_ff, "read position past order length")
   `TSE_ASSERT_NEXT(a_edge_follow, state_ff == S_STEP && top_cur_ff != NIL, state_ff == S_EDGE, "edge fetch skipped")
   `TSE_ASSERT_NOW(a_step_depth, state_ff == S_STEP, sp_ff != '0, "step with empty stack")

endmodule
